// ===== rtl/eulr_pkg.sv =====
package eulr_pkg;

  // Field widths
  localparam int RATE_BITS = 16;
  localparam int SRATE_BITS = 14;
  localparam int DEG_BITS = 9;
  localparam int OUT_BITS = 16;
  localparam int NUM_AXES = 3;

  // Fixed-point format of the sine table and the matrix entries
  localparam int FRAC_BITS = 14;
  localparam int PROD_BITS = FRAC_BITS + 4;
  localparam int SUM_BITS = PROD_BITS + 1;

  // One full turn in degrees
  localparam int DEG_TURN = 360;

  // Divider: two quotient bits per stage
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = RATE_BITS / DIV_BITS_PER_STAGE;

  // Default queue depths
  localparam int MID_DEPTH_DEF = 16;
  localparam int OUT_DEPTH_DEF = 8;

  // Register map
  localparam logic [2:0] ADDR_SAMPLE_RATE = 3'h0;
  localparam logic [SRATE_BITS-1:0] SAMPLE_RATE_RESET = SRATE_BITS'(100);

  // round(16384 * sin(d)) for d = 0..90
  localparam logic [14:0] QSINE [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5871,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421, 15'd13583,
    15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466, 15'd14598,
    15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396,
    15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
    15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16361, 15'd16374, 15'd16382, 15'd16384
  };

  // Divider lane: sign of the quotient, partial remainder, dividend/quotient
  typedef struct packed {
    logic neg;
    logic [SRATE_BITS-1:0] rem;
    logic [RATE_BITS-1:0] acc;
  } div_lane_t;

  // Wrapped whole-degree angles handed from front to back
  typedef struct packed {
    logic [DEG_BITS-1:0] roll;
    logic [DEG_BITS-1:0] pitch;
    logic [DEG_BITS-1:0] yaw;
  } angles_t;

  // One result transfer
  typedef struct packed {
    logic signed [OUT_BITS-1:0] m00;
    logic signed [OUT_BITS-1:0] m01;
    logic signed [OUT_BITS-1:0] m02;
    logic signed [OUT_BITS-1:0] m10;
    logic signed [OUT_BITS-1:0] m11;
    logic signed [OUT_BITS-1:0] m12;
    logic signed [OUT_BITS-1:0] m20;
    logic signed [OUT_BITS-1:0] m21;
    logic signed [OUT_BITS-1:0] m22;
  } result_t;

  // One restoring division step
  function automatic div_lane_t div_step(div_lane_t x, logic [SRATE_BITS-1:0] dvs);
    logic [SRATE_BITS:0] trial;
    div_lane_t y;
    y = x;
    trial = {x.rem, x.acc[RATE_BITS-1]};
    y.acc = {x.acc[RATE_BITS-2:0], 1'b0};
    if (trial >= {1'b0, dvs}) begin
      y.rem = SRATE_BITS'(trial - {1'b0, dvs});
      y.acc[0] = 1'b1;
    end else begin
      y.rem = trial[SRATE_BITS-1:0];
    end
    return y;
  endfunction

  function automatic div_lane_t div_stage(div_lane_t x, logic [SRATE_BITS-1:0] dvs);
    div_lane_t y;
    y = x;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      y = div_step(y, dvs);
    end
    return y;
  endfunction

  // Strip multiples of 64..8 turns: result below 8 turns
  function automatic logic [11:0] mod_turn_hi(logic [RATE_BITS-1:0] q);
    logic [RATE_BITS-1:0] v;
    v = q;
    for (int k = 6; k >= 3; k--) begin
      if (v >= RATE_BITS'(DEG_TURN << k)) v = v - RATE_BITS'(DEG_TURN << k);
    end
    return v[11:0];
  endfunction

  // Strip the last turns and fold a negative quotient back into 0..359
  function automatic logic [DEG_BITS-1:0] mod_turn_lo(logic [11:0] q, logic neg);
    logic [11:0] v;
    logic [DEG_BITS-1:0] r;
    v = q;
    for (int k = 2; k >= 0; k--) begin
      if (v >= 12'(DEG_TURN << k)) v = v - 12'(DEG_TURN << k);
    end
    r = v[DEG_BITS-1:0];
    if (neg && (r != '0)) r = DEG_BITS'(DEG_TURN) - r;
    return r;
  endfunction

  // Sine of a whole degree 0..359 in Q1.14
  function automatic logic signed [PROD_BITS-1:0] sin_deg(logic [DEG_BITS-1:0] d);
    logic [6:0] idx;
    logic neg;
    logic signed [PROD_BITS-1:0] mag;
    if (d <= 9'd90) begin
      idx = 7'(d);
      neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx = 7'(9'd180 - d);
      neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx = 7'(d - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - d);
      neg = 1'b1;
    end
    mag = PROD_BITS'(QSINE[idx]);
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [PROD_BITS-1:0] cos_deg(logic [DEG_BITS-1:0] d);
    logic [DEG_BITS-1:0] e;
    e = (d >= 9'd270) ? (d - 9'd270) : (d + 9'd90);
    return sin_deg(e);
  endfunction

  // Product with arithmetic shift right (rounds toward minus infinity)
  function automatic logic signed [PROD_BITS-1:0] qmul(logic signed [PROD_BITS-1:0] a,
                                                       logic signed [PROD_BITS-1:0] b);
    logic signed [2*PROD_BITS-1:0] p;
    p = a * b;
    return PROD_BITS'(p >>> FRAC_BITS);
  endfunction

  // Saturate to +-1.0
  function automatic logic signed [OUT_BITS-1:0] qsat(logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] one;
    one = SUM_BITS'(1) <<< FRAC_BITS;
    if (v > one) return OUT_BITS'(one);
    if (v < -one) return OUT_BITS'(-one);
    return OUT_BITS'(v);
  endfunction

endpackage

// ===== rtl/euler_rate_rotation_matrix.sv =====
// ZYX Euler rotation matrix from one gyro sample.
// Input side is a queue: drive roll_rate, pitch_rate and yaw_rate with push;
// a transfer happens on a clock edge with push high and full low.
// Result side is a queue: while empty is low, m00..m22 hold the oldest result
// in Q1.14; a transfer happens on a clock edge with pop high and empty low.
// sample_rate (byte address 0, APB write, pready always high) divides each
// rate; zero acts as one. Write it only while the block is drained.
// Throughput: one sample per cycle while full is low. An input transfer
// reaches the output queue through the 11-stage front (8-stage radix-4
// divider and two modulo stages), the middle queue and the 4-stage
// table/multiply back end.
// When the receiver stalls, results collect in the output queue; once the
// back end has no room it stops draining the middle queue, and full rises
// when the middle queue is committed, so no sample is ever dropped.
// Reset empties both queues, clears all valid bits and sets sample_rate to
// 100.
module euler_rate_rotation_matrix
  import eulr_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // samples
  input  logic                        push,
  output logic                        full,
  input  logic signed [RATE_BITS-1:0] roll_rate,
  input  logic signed [RATE_BITS-1:0] pitch_rate,
  input  logic signed [RATE_BITS-1:0] yaw_rate,
  // results
  output logic                        empty,
  input  logic                        pop,
  output logic signed [OUT_BITS-1:0]  m00,
  output logic signed [OUT_BITS-1:0]  m01,
  output logic signed [OUT_BITS-1:0]  m02,
  output logic signed [OUT_BITS-1:0]  m10,
  output logic signed [OUT_BITS-1:0]  m11,
  output logic signed [OUT_BITS-1:0]  m12,
  output logic signed [OUT_BITS-1:0]  m20,
  output logic signed [OUT_BITS-1:0]  m21,
  output logic signed [OUT_BITS-1:0]  m22
);

  localparam int MID_CNT_BITS = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  logic [SRATE_BITS-1:0] sample_rate;
  logic [SRATE_BITS-1:0] divisor;
  logic cfg_wr;

  logic in_xfer;
  logic out_xfer;
  logic mid_pop;
  logic mid_empty;
  logic front_valid;
  angles_t front_angles;
  angles_t mid_angles;
  logic back_valid;
  result_t back_result;
  result_t head;

  logic [MID_CNT_BITS-1:0] front_occ;
  logic [OUT_CNT_BITS-1:0] back_occ;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ADDR_SAMPLE_RATE[2]) ? 32'(sample_rate) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RESET;
    end else if (cfg_wr && (paddr[2] == ADDR_SAMPLE_RATE[2])) begin
      sample_rate <= pwdata[SRATE_BITS-1:0];
    end
  end

  assign divisor = (sample_rate == '0) ? SRATE_BITS'(1) : sample_rate;

  // Credits: front holds samples not yet taken from the middle queue,
  // back holds results not yet popped from the output queue
  assign full = (front_occ == MID_CNT_BITS'(MID_DEPTH));
  assign in_xfer = push && !full;
  assign mid_pop = !mid_empty && (back_occ < OUT_CNT_BITS'(OUT_DEPTH));
  assign out_xfer = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_occ <= '0;
      back_occ <= '0;
    end else begin
      front_occ <= front_occ + MID_CNT_BITS'(in_xfer) - MID_CNT_BITS'(mid_pop);
      back_occ <= back_occ + OUT_CNT_BITS'(mid_pop) - OUT_CNT_BITS'(out_xfer);
    end
  end

  eulr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_xfer),
    .roll_rate  (roll_rate),
    .pitch_rate (pitch_rate),
    .yaw_rate   (yaw_rate),
    .divisor    (divisor),
    .out_valid  (front_valid),
    .out_angles (front_angles)
  );

  eulr_queue #(
    .WIDTH ($bits(angles_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_angles),
    .pop   (mid_pop),
    .rdata (mid_angles),
    .empty (mid_empty)
  );

  eulr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mid_pop),
    .in_angles  (mid_angles),
    .out_valid  (back_valid),
    .out_result (back_result)
  );

  eulr_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .wdata (back_result),
    .pop   (out_xfer),
    .rdata (head),
    .empty (empty)
  );

  assign m00 = head.m00;
  assign m01 = head.m01;
  assign m02 = head.m02;
  assign m10 = head.m10;
  assign m11 = head.m11;
  assign m12 = head.m12;
  assign m20 = head.m20;
  assign m21 = head.m21;
  assign m22 = head.m22;

  // Credit counters stay within the queue depths
  a_front_occ: assert property (@(posedge clk) disable iff (rst)
    front_occ <= MID_CNT_BITS'(MID_DEPTH))
    else $error("front credit count exceeds middle queue depth");

  a_back_occ: assert property (@(posedge clk) disable iff (rst)
    back_occ <= OUT_CNT_BITS'(OUT_DEPTH))
    else $error("back credit count exceeds output queue depth");

  // Nothing outstanding means nothing to show
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (front_occ == '0 && back_occ == '0) |-> empty)
    else $error("result shown with no sample outstanding");

  // Entry m00 is saturated to plus or minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (m00 <= OUT_BITS'(1 << FRAC_BITS) && m00 >= -OUT_BITS'(1 << FRAC_BITS)))
    else $error("m00 outside saturation range");

endmodule

// ===== rtl/eulr_queue.sv =====
module eulr_queue
  import eulr_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic do_pop;

  assign empty = (count == '0);
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  // Storage; space is guaranteed by the caller's credit count
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(do_pop);
    end
  end

endmodule

// ===== rtl/eulr_front.sv =====
module eulr_front
  import eulr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [RATE_BITS-1:0]  roll_rate,
  input  logic signed [RATE_BITS-1:0]  pitch_rate,
  input  logic signed [RATE_BITS-1:0]  yaw_rate,
  input  logic [SRATE_BITS-1:0]        divisor,
  output logic                         out_valid,
  output angles_t                      out_angles
);

  // Capture, divider stages, two modulo stages
  localparam int LAT = 1 + DIV_STAGES + 2;

  logic [LAT-1:0] vld;
  div_lane_t lane [DIV_STAGES+1][NUM_AXES];
  logic [11:0] part [NUM_AXES];
  logic part_neg [NUM_AXES];
  logic [DEG_BITS-1:0] deg [NUM_AXES];
  logic signed [RATE_BITS-1:0] rate_in [NUM_AXES];

  assign rate_in[0] = roll_rate;
  assign rate_in[1] = pitch_rate;
  assign rate_in[2] = yaw_rate;

  // Valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Capture sign and magnitude of each rate, then the divider pipeline,
  // truncating toward zero on magnitudes
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lane[0][a].neg <= rate_in[a][RATE_BITS-1];
      lane[0][a].rem <= '0;
      lane[0][a].acc <= rate_in[a][RATE_BITS-1] ? RATE_BITS'(-rate_in[a])
                                                : RATE_BITS'(rate_in[a]);
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lane[s+1][a] <= div_stage(lane[s][a], divisor);
      end
    end
  end

  // Wrap into one turn
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      part[a] <= mod_turn_hi(lane[DIV_STAGES][a].acc);
      part_neg[a] <= lane[DIV_STAGES][a].neg;
      deg[a] <= mod_turn_lo(part[a], part_neg[a]);
    end
  end

  assign out_valid = vld[LAT-1];
  assign out_angles.roll = deg[0];
  assign out_angles.pitch = deg[1];
  assign out_angles.yaw = deg[2];

endmodule

// ===== rtl/eulr_back.sv =====
module eulr_back
  import eulr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  angles_t in_angles,
  output logic    out_valid,
  output result_t out_result
);

  localparam int LAT = 4;

  logic [LAT-1:0] vld;

  // Stage 1: table reads
  logic signed [PROD_BITS-1:0] sr, cr, sp, cp, sy, cy;
  // Stage 2: two-factor products
  logic signed [PROD_BITS-1:0] cycp, sycp, cysp, sysp, cpsr, cpcr;
  logic signed [PROD_BITS-1:0] sycr, cycr, sysr, cysr, sr2, cr2, sp2;
  // Stage 3: three-factor products
  logic signed [PROD_BITS-1:0] t_cyspsr, t_cyspcr, t_sysp_sr, t_sysp_cr;
  logic signed [PROD_BITS-1:0] cycp3, sycp3, cpsr3, cpcr3, sycr3, cycr3;
  logic signed [PROD_BITS-1:0] sysr3, cysr3, sp3;

  // Valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // sine and cosine of each angle
    sr <= sin_deg(in_angles.roll);
    cr <= cos_deg(in_angles.roll);
    sp <= sin_deg(in_angles.pitch);
    cp <= cos_deg(in_angles.pitch);
    sy <= sin_deg(in_angles.yaw);
    cy <= cos_deg(in_angles.yaw);

    // first products
    cycp <= qmul(cy, cp);
    sycp <= qmul(sy, cp);
    cysp <= qmul(cy, sp);
    sysp <= qmul(sy, sp);
    cpsr <= qmul(cp, sr);
    cpcr <= qmul(cp, cr);
    sycr <= qmul(sy, cr);
    cycr <= qmul(cy, cr);
    sysr <= qmul(sy, sr);
    cysr <= qmul(cy, sr);
    sr2 <= sr;
    cr2 <= cr;
    sp2 <= sp;

    // second products, left to right
    t_cyspsr <= qmul(cysp, sr2);
    t_cyspcr <= qmul(cysp, cr2);
    t_sysp_sr <= qmul(sysp, sr2);
    t_sysp_cr <= qmul(sysp, cr2);
    cycp3 <= cycp;
    sycp3 <= sycp;
    cpsr3 <= cpsr;
    cpcr3 <= cpcr;
    sycr3 <= sycr;
    cycr3 <= cycr;
    sysr3 <= sysr;
    cysr3 <= cysr;
    sp3 <= sp2;

    // sums and saturation
    out_result.m00 <= qsat(SUM_BITS'(cycp3));
    out_result.m01 <= qsat(SUM_BITS'(sycp3));
    out_result.m02 <= qsat(-SUM_BITS'(sp3));
    out_result.m10 <= qsat(SUM_BITS'(t_cyspsr) - SUM_BITS'(sycr3));
    out_result.m11 <= qsat(SUM_BITS'(t_sysp_sr) + SUM_BITS'(cycr3));
    out_result.m12 <= qsat(SUM_BITS'(cpsr3));
    out_result.m20 <= qsat(SUM_BITS'(t_cyspcr) + SUM_BITS'(sysr3));
    out_result.m21 <= qsat(SUM_BITS'(t_sysp_cr) - SUM_BITS'(cysr3));
    out_result.m22 <= qsat(SUM_BITS'(cpcr3));
  end

  assign out_valid = vld[LAT-1];

endmodule
